/* hdl/ptt_pkg.sv */
// shared types and codes for the periodic timer table
package ptt_pkg;

  // command codes carried by an input item
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_FIRED = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FULL  = 2'd2
  } kind_t;

  localparam int CMD_W   = 2;
  localparam int ID_W    = 16;
  localparam int TIME_W  = 32;
  localparam int KIND_W  = 2;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic close;
  } ptt_ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } ptt_sts_t;

endpackage

/* hdl/ptt_if.sv */
// valid/ready channel interfaces for commands and results
interface ptt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] timer_id;
  logic [31:0] interval_ms;
  logic [31:0] now_ms;

  modport source (output valid, cmd, timer_id, interval_ms, now_ms, input ready);
  modport sink (input valid, cmd, timer_id, interval_ms, now_ms, output ready);
endinterface

interface ptt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] fired_id;
  logic        last_of_run;

  modport source (output valid, kind, fired_id, last_of_run, input ready);
  modport sink (input valid, kind, fired_id, last_of_run, output ready);
endinterface

/* hdl/periodic_timer_table_top.sv */
// periodic timer table top level
//
//  channel  dir  handshake     payload
//  in_ch    in   valid/ready   cmd, timer_id, interval_ms, now_ms
//  out_ch   out  valid/ready   kind, fired_id, last_of_run
//
// tick, add and remove walk every slot, reading one slot per cycle from the
// slot memories; remove all skips the walk.
// each fired result that finds the result register still full holds the walk.
// reset (synchronous, rst_n low) clears all slot marks and the last tick time.
// a new command is taken as soon as the closing result is in the result register.
module periodic_timer_table_top import ptt_pkg::*; #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  ptt_in_if.sink     in_ch,
  ptt_out_if.source  out_ch
);

  ptt_ctl_t ctl;
  ptt_sts_t sts;

  // sequencer
  ptt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // storage and result path
  ptt_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_cmd          (in_ch.cmd),
    .in_timer_id     (in_ch.timer_id),
    .in_interval_ms  (in_ch.interval_ms),
    .in_now_ms       (in_ch.now_ms),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_kind        (out_ch.kind),
    .out_fired_id    (out_ch.fired_id),
    .out_last_of_run (out_ch.last_of_run)
  );

endmodule

/* hdl/ptt_ctrl.sv */
// command sequencer for the periodic timer table
module ptt_ctrl import ptt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_cmd,
  output logic        in_ready,
  input  ptt_sts_t    sts,
  output ptt_ctl_t    ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_CLOSE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  cmd_t   op_r;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (cmd_t'(in_cmd) == CMD_CLEAR) ? S_CLOSE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = (op_r == CMD_TICK) ? S_CLOSE : S_APPLY;
        end
      end
      S_APPLY: state_nxt = S_CLOSE;
      S_CLOSE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and latched command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= CMD_TICK;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        op_r <= cmd_t'(in_cmd);
      end
    end
  end

  // datapath commands
  always_comb begin
    ctl.load  = accept;
    ctl.scan  = (state_r == S_SCAN);
    ctl.apply = (state_r == S_APPLY);
    ctl.close = (state_r == S_CLOSE);
  end

endmodule

/* hdl/ptt_datapath.sv */
// slot storage, slot walk, update logic and result register
module ptt_datapath import ptt_pkg::*; #(
  parameter int TIMER_SLOTS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ptt_ctl_t          ctl,
  output ptt_sts_t          sts,
  input  logic [1:0]        in_cmd,
  input  logic [ID_W-1:0]   in_timer_id,
  input  logic [TIME_W-1:0] in_interval_ms,
  input  logic [TIME_W-1:0] in_now_ms,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_kind,
  output logic [ID_W-1:0]   out_fired_id,
  output logic              out_last_of_run
);

  localparam int SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

  // latched item
  cmd_t              op_r;
  logic [ID_W-1:0]   tid_r;
  logic [TIME_W-1:0] ival_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] last_tick_r;

  // slot marks in flops
  logic [TIMER_SLOTS-1:0] slot_valid_r;
  logic [TIMER_SLOTS-1:0] slot_pend_r;

  // slot memories
  logic [ID_W-1:0]   id_mem   [TIMER_SLOTS];
  logic [TIME_W-1:0] ival_mem [TIMER_SLOTS];
  logic [TIME_W-1:0] last_mem [TIMER_SLOTS];
  logic [ID_W-1:0]   id_q_r;
  logic [TIME_W-1:0] ival_q_r;
  logic [TIME_W-1:0] last_q_r;

  // walk pipeline
  logic [CNT_W-1:0]  rd_addr_r;
  logic              ev_valid_r;
  logic [SLOT_W-1:0] ev_slot_r;
  logic              match_found_r;
  logic [SLOT_W-1:0] match_slot_r;
  logic              free_found_r;
  logic [SLOT_W-1:0] free_slot_r;

  // result register
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_last_r;

  logic              out_free;
  logic              issue_ok;
  logic              rd_en;
  logic              is_tick;
  logic              ev_v;
  logic              ev_p;
  logic [TIME_W-1:0] elapsed;
  logic              due;
  logic              stall;
  logic              fire_push;
  logic              tick_free;
  logic              hit;
  logic              hole;
  logic              add_hit;
  logic              add_new;
  logic              rem_hit;
  logic              close_push;
  kind_t             close_kind;
  logic              last_we;
  logic [SLOT_W-1:0] last_wa;
  logic [TIME_W-1:0] last_wd;
  logic              ival_we;
  logic [SLOT_W-1:0] ival_wa;

  assign out_free = !out_valid_r || out_ready;
  assign issue_ok = (rd_addr_r != CNT_W'(TIMER_SLOTS));
  assign is_tick  = (op_r == CMD_TICK);

  // evaluation of the slot whose data is in the read registers
  assign ev_v      = slot_valid_r[ev_slot_r];
  assign ev_p      = slot_pend_r[ev_slot_r];
  assign elapsed   = now_r - last_q_r;
  assign due       = ev_valid_r && is_tick && ev_v && !ev_p && (elapsed >= ival_q_r);
  assign stall     = due && !out_free;
  assign fire_push = due && out_free;
  assign tick_free = ev_valid_r && is_tick && ev_v && ev_p;
  assign hit       = ev_valid_r && !is_tick && ev_v && (id_q_r == tid_r);
  assign hole      = ev_valid_r && !is_tick && !ev_v;
  assign rd_en     = ctl.scan && issue_ok && !stall;

  // end-of-walk updates for add and remove
  assign add_hit = ctl.apply && (op_r == CMD_ADD) && match_found_r;
  assign add_new = ctl.apply && (op_r == CMD_ADD) && !match_found_r && free_found_r;
  assign rem_hit = ctl.apply && (op_r == CMD_REMOVE) && match_found_r;

  // closing result
  assign close_push = ctl.close && out_free;
  assign close_kind = ((op_r == CMD_ADD) && !match_found_r && !free_found_r) ?
                      KIND_FULL : KIND_DONE;

  // memory write ports
  assign last_we = fire_push || add_new;
  assign last_wa = fire_push ? ev_slot_r : free_slot_r;
  assign last_wd = fire_push ? now_r : last_tick_r;
  assign ival_we = add_hit || add_new;
  assign ival_wa = match_found_r ? match_slot_r : free_slot_r;

  // item latch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tick_r <= '0;
    end else if (ctl.load && (cmd_t'(in_cmd) == CMD_TICK)) begin
      last_tick_r <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_r   <= cmd_t'(in_cmd);
      tid_r  <= in_timer_id;
      ival_r <= in_interval_ms;
      now_r  <= in_now_ms;
    end
  end

  // slot walk: issue a registered read, then evaluate the slot from the read registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r     <= '0;
      ev_valid_r    <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (ctl.load) begin
      rd_addr_r     <= '0;
      ev_valid_r    <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else begin
      if (!stall) begin
        ev_valid_r <= rd_en;
        if (rd_en) begin
          rd_addr_r <= rd_addr_r + CNT_W'(1);
        end
      end
      if (hit && !match_found_r) begin
        match_found_r <= 1'b1;
      end
      if (hole && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      ev_slot_r <= rd_addr_r[SLOT_W-1:0];
    end
    if (hit && !match_found_r) begin
      match_slot_r <= ev_slot_r;
    end
    if (hole && !free_found_r) begin
      free_slot_r <= ev_slot_r;
    end
  end

  // valid and pending-delete marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
      slot_pend_r  <= '0;
    end else begin
      if (tick_free) begin
        slot_valid_r[ev_slot_r] <= 1'b0;
        slot_pend_r[ev_slot_r]  <= 1'b0;
      end
      if (add_hit) begin
        slot_pend_r[match_slot_r] <= 1'b0;
      end
      if (add_new) begin
        slot_valid_r[free_slot_r] <= 1'b1;
        slot_pend_r[free_slot_r]  <= 1'b0;
      end
      if (rem_hit) begin
        slot_pend_r[match_slot_r] <= 1'b1;
      end
      if (close_push && (op_r == CMD_CLEAR)) begin
        slot_valid_r <= '0;
        slot_pend_r  <= '0;
      end
    end
  end

  // slot memories, one write and one registered read each
  always_ff @(posedge clk) begin
    if (add_new) begin
      id_mem[free_slot_r] <= tid_r;
    end
    if (rd_en) begin
      id_q_r <= id_mem[rd_addr_r[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ival_we) begin
      ival_mem[ival_wa] <= ival_r;
    end
    if (rd_en) begin
      ival_q_r <= ival_mem[rd_addr_r[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (last_we) begin
      last_mem[last_wa] <= last_wd;
    end
    if (rd_en) begin
      last_q_r <= last_mem[rd_addr_r[SLOT_W-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire_push || close_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_push) begin
      out_kind_r <= KIND_FIRED;
      out_id_r   <= id_q_r;
      out_last_r <= 1'b0;
    end else if (close_push) begin
      out_kind_r <= close_kind;
      out_id_r   <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_fired_id    = out_id_r;
  assign out_last_of_run = out_last_r;

  assign sts.scan_done = !issue_ok && !ev_valid_r;
  assign sts.out_free  = out_free;

endmodule

/* hdl/ptt_checker.sv */
// port-level checks for the periodic timer table, bound to the top level
module ptt_checker import ptt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [KIND_W-1:0] out_kind,
  input logic [ID_W-1:0]   out_fired_id,
  input logic              out_last_of_run
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
      $stable(out_fired_id) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // only fired results leave a run open
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == KIND_FIRED) == !out_last_of_run))
    else $error("last_of_run does not match kind");

  // closing results carry no id
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_FIRED) |-> (out_fired_id == '0))
    else $error("non-fired result with nonzero id");

  // no undefined kind code
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_FIRED || out_kind == KIND_DONE ||
      out_kind == KIND_FULL))
    else $error("undefined result kind");

  // a command transfer is followed by a busy cycle
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken on back-to-back cycles");

endmodule

bind periodic_timer_table_top ptt_checker u_ptt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_fired_id    (out_ch.fired_id),
  .out_last_of_run (out_ch.last_of_run)
);

/* verif/tb_top.sv */
// self-checking testbench for the periodic timer table: directed and random command streams
module tb_top import ptt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TIMER_SLOTS  = 32;
  localparam int LIMIT_CYCLES = 900000;
  localparam int DRAIN_CYCLES = TIMER_SLOTS + 8;
  localparam int POOL_SIZE    = 40;
  localparam int MAX_GAP      = 40;
  localparam int PRINT_CAP    = 50;

  typedef struct {
    kind_t           kind;
    logic [ID_W-1:0] fired_id;
    logic            last_of_run;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ptt_in_if  in_if ();
  ptt_out_if out_if ();

  periodic_timer_table_top #(.TIMER_SLOTS(TIMER_SLOTS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // shadow copy of the timer table
  bit                mdl_valid     [TIMER_SLOTS];
  bit                mdl_pend_del  [TIMER_SLOTS];
  logic [ID_W-1:0]   mdl_id        [TIMER_SLOTS];
  logic [TIME_W-1:0] mdl_interval  [TIMER_SLOTS];
  logic [TIME_W-1:0] mdl_last_fire [TIMER_SLOTS];
  logic [TIME_W-1:0] mdl_last_tick;

  timer_result_t     timer_results_q[$];
  int                mismatch_count;
  int                send_idle_pct;
  int                recv_idle_pct;
  longint            cycle_count;
  logic [TIME_W-1:0] now_time;
  logic [ID_W-1:0]   id_pool [POOL_SIZE];

  // clock
  always #10ns clk = ~clk;

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver backpressure, changed on the falling edge
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checking on every output transfer
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      check_result();
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, exp);
    end
    mismatch_count++;
  endtask

  task automatic check_result();
    timer_result_t exp;
    if (timer_results_q.size() == 0) begin
      report_mismatch("unexpected result kind", 32'(out_if.kind), 32'(0));
    end else begin
      exp = timer_results_q.pop_front();
      if (out_if.kind !== exp.kind)
        report_mismatch("kind", 32'(out_if.kind), 32'(exp.kind));
      if (out_if.fired_id !== exp.fired_id)
        report_mismatch("fired_id", 32'(out_if.fired_id), 32'(exp.fired_id));
      if (out_if.last_of_run !== exp.last_of_run)
        report_mismatch("last_of_run", 32'(out_if.last_of_run), 32'(exp.last_of_run));
    end
  endtask

  // queue one awaited result at the back
  task automatic expect_result(kind_t kind, logic [ID_W-1:0] id, logic last);
    timer_result_t r;
    r = '{kind, id, last};
    timer_results_q = {timer_results_q, r};
  endtask

  function automatic int find_slot(logic [ID_W-1:0] id);
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (mdl_valid[i] && mdl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // id that is not in the table yet
  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    id = 16'($urandom);
    while (find_slot(id) >= 0) id = 16'($urandom);
    return id;
  endfunction

  // apply one accepted command to the shadow table and queue its results
  task automatic run_timer_table(cmd_t cmd, logic [ID_W-1:0] id,
                                 logic [TIME_W-1:0] interval, logic [TIME_W-1:0] now);
    int                s;
    logic [TIME_W-1:0] elapsed;
    s = -1;
    case (cmd)
      CMD_TICK: begin
        mdl_last_tick = now;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (mdl_valid[i]) begin
            if (mdl_pend_del[i]) begin
              mdl_valid[i]    = 1'b0;
              mdl_pend_del[i] = 1'b0;
            end else begin
              elapsed = now - mdl_last_fire[i];
              if (elapsed >= mdl_interval[i]) begin
                mdl_last_fire[i] = now;
                expect_result(KIND_FIRED, mdl_id[i], 1'b0);
              end
            end
          end
        end
        expect_result(KIND_DONE, '0, 1'b1);
      end
      CMD_ADD: begin
        s = find_slot(id);
        if (s >= 0) begin
          // existing id: revive and re-interval, keep last fire
          mdl_pend_del[s] = 1'b0;
          mdl_interval[s] = interval;
          expect_result(KIND_DONE, '0, 1'b1);
        end else begin
          for (int i = 0; i < TIMER_SLOTS && s < 0; i++) begin
            if (!mdl_valid[i]) s = i;
          end
          if (s >= 0) begin
            mdl_valid[s]     = 1'b1;
            mdl_pend_del[s]  = 1'b0;
            mdl_id[s]        = id;
            mdl_interval[s]  = interval;
            mdl_last_fire[s] = mdl_last_tick;
            expect_result(KIND_DONE, '0, 1'b1);
          end else begin
            expect_result(KIND_FULL, '0, 1'b1);
          end
        end
      end
      CMD_REMOVE: begin
        s = find_slot(id);
        if (s >= 0) mdl_pend_del[s] = 1'b1;
        expect_result(KIND_DONE, '0, 1'b1);
      end
      default: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          mdl_valid[i]    = 1'b0;
          mdl_pend_del[i] = 1'b0;
        end
        expect_result(KIND_DONE, '0, 1'b1);
      end
    endcase
  endtask

  // one input transfer, with a random idle gap in front
  task automatic send_item(cmd_t cmd, logic [ID_W-1:0] id,
                           logic [TIME_W-1:0] interval, logic [TIME_W-1:0] now);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd;
    in_if.timer_id    <= id;
    in_if.interval_ms <= interval;
    in_if.now_ms      <= now;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    run_timer_table(cmd, id, interval, now);
  endtask

  task automatic send_tick(logic [TIME_W-1:0] now);
    now_time = now;
    send_item(CMD_TICK, 16'($urandom), $urandom, now);
  endtask

  // hold the sender until every awaited result has come back
  task automatic wait_results_drained();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (timer_results_q.size() != 0) @(posedge clk);
  endtask

  // empty tick, zero interval, extreme ids and intervals
  task automatic test_basic_firing();
    send_tick(32'h0000_0000);
    send_item(CMD_ADD, 16'h0000, 32'h0000_0000, $urandom);
    send_item(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF, $urandom);
    send_item(CMD_ADD, 16'h1234, 32'd10, $urandom);
    send_tick(32'd5);
    send_tick(32'd15);
  endtask

  // update of a present id, revive of an id pending delete
  task automatic test_update_and_revive();
    send_item(CMD_ADD, 16'h1234, 32'd100, $urandom);
    send_item(CMD_REMOVE, 16'h1234, $urandom, $urandom);
    send_item(CMD_ADD, 16'h1234, 32'd1, $urandom);
    send_tick(32'd16);
  endtask

  // remove of known and unknown ids, time wraparound
  task automatic test_remove_and_wrap();
    send_item(CMD_REMOVE, 16'hFFFF, $urandom, $urandom);
    send_item(CMD_REMOVE, 16'h5555, $urandom, $urandom);
    send_tick(32'hFFFF_FFFF);
    send_item(CMD_ADD, 16'hAAAA, 32'h8000_0000, $urandom);
    send_tick(32'h0000_0000);
    send_tick(32'h7FFF_FFFF);
  endtask

  // remove all, also over entries pending delete
  task automatic test_remove_all();
    send_item(CMD_REMOVE, 16'h0000, $urandom, $urandom);
    send_tick(32'h8000_0000);
    send_item(CMD_ADD, 16'h3C3C, 32'd5, $urandom);
    send_item(CMD_REMOVE, 16'h3C3C, $urandom, $urandom);
    send_item(CMD_CLEAR, 16'($urandom), $urandom, $urandom);
    send_tick(32'hFFFF_FFF0);
    send_item(CMD_ADD, 16'h5A5A, 32'h0000_0000, $urandom);
    send_tick(32'hFFFF_FFF8);
  endtask

  // fill the table, refuse adds while full, free a slot through tick
  task automatic test_table_full();
    int added;
    send_item(CMD_CLEAR, 16'($urandom), $urandom, $urandom);
    added = 0;
    while (added < TIMER_SLOTS + 2) begin
      send_item(CMD_ADD, fresh_id(), $urandom_range(300), $urandom);
      added++;
    end
    send_item(CMD_ADD, mdl_id[5], 32'd0, $urandom);
    send_item(CMD_REMOVE, mdl_id[9], $urandom, $urandom);
    // slot pending delete is still taken
    send_item(CMD_ADD, fresh_id(), $urandom_range(300), $urandom);
    send_tick(now_time + 32'd50);
    send_item(CMD_ADD, fresh_id(), $urandom_range(300), $urandom);
    send_tick(now_time + 32'd400);
  endtask

  // random command mix over a small id pool
  task automatic test_random_mix(int n_items);
    int                roll;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] ivl;
    for (int k = 0; k < n_items; k++) begin
      if (k == n_items / 2) wait_results_drained();
      id = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(POOL_SIZE - 1)];
      roll = $urandom_range(9);
      if (roll < 7) ivl = $urandom_range(150);
      else if (roll < 9) ivl = $urandom_range(2000);
      else ivl = $urandom;
      roll = $urandom_range(99);
      if (roll < 40) begin
        if ($urandom_range(19) == 0) send_tick($urandom);
        else send_tick(now_time + $urandom_range(120));
      end else if (roll < 72) begin
        send_item(CMD_ADD, id, ivl, $urandom);
      end else if (roll < 97) begin
        send_item(CMD_REMOVE, id, $urandom, $urandom);
      end else begin
        send_item(CMD_CLEAR, id, $urandom, $urandom);
      end
    end
  endtask

  // test sequence
  initial begin
    rst_n             = 1'b0;
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_TICK;
    in_if.timer_id    = '0;
    in_if.interval_ms = '0;
    in_if.now_ms      = '0;
    out_if.ready      = 1'b0;
    mismatch_count    = 0;
    cycle_count       = 0;
    now_time          = '0;
    mdl_last_tick     = '0;
    send_idle_pct     = 29;
    recv_idle_pct     = 69;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      mdl_valid[i]    = 1'b0;
      mdl_pend_del[i] = 1'b0;
    end
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_firing();
    test_update_and_revive();
    test_remove_and_wrap();
    test_remove_all();
    test_table_full();
    test_random_mix(70);

    send_idle_pct = 69;
    recv_idle_pct = 29;
    test_random_mix(90);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(90);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
